// ----- rtl/shnc_pkg.sv -----
// ----------------------------------------------------------------------------
// shnc_pkg
// Types, name table and code constants for the SIP header name classifier.
// ----------------------------------------------------------------------------
package shnc_pkg;

  localparam int NUM_NAMES   = 13;
  localparam int NAME_CHARS  = 14;
  localparam int ROUTE_INDEX = 6;

  typedef logic [NUM_NAMES-1:0] flags_t;

  typedef enum logic [3:0] {
    KIND_OTHER          = 4'd0,
    KIND_TO             = 4'd1,
    KIND_VIA            = 4'd2,
    KIND_FROM           = 4'd3,
    KIND_CSEQ           = 4'd4,
    KIND_RSEQ           = 4'd5,
    KIND_RACK           = 4'd6,
    KIND_ROUTE          = 4'd7,
    KIND_CALL_ID        = 4'd8,
    KIND_CONTACT        = 4'd9,
    KIND_REQUIRE        = 4'd10,
    KIND_CONTENT_TYPE   = 4'd11,
    KIND_RECORD_ROUTE   = 4'd12,
    KIND_CONTENT_LENGTH = 4'd13
  } kind_t;

  // compact form letters
  localparam logic [7:0] CHAR_I = 8'h69;
  localparam logic [7:0] CHAR_M = 8'h6d;
  localparam logic [7:0] CHAR_L = 8'h6c;
  localparam logic [7:0] CHAR_C = 8'h63;
  localparam logic [7:0] CHAR_F = 8'h66;
  localparam logic [7:0] CHAR_T = 8'h74;
  localparam logic [7:0] CHAR_V = 8'h76;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CASE_OFFSET  = 8'h20;

  // lowercase names, left aligned, padded with spaces
  localparam logic [8*NAME_CHARS-1:0] NAME_STR [NUM_NAMES] = '{
    "to            ",
    "via           ",
    "from          ",
    "cseq          ",
    "rseq          ",
    "rack          ",
    "route         ",
    "call-id       ",
    "contact       ",
    "require       ",
    "content-type  ",
    "record-route  ",
    "content-length"
  };

  localparam logic [3:0] NAME_LEN [NUM_NAMES] = '{
    4'd2, 4'd3, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5,
    4'd7, 4'd7, 4'd7, 4'd12, 4'd12, 4'd14
  };

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r = c + CASE_OFFSET;
    end
    return r;
  endfunction

  function automatic logic [7:0] name_byte(input logic [3:0] idx, input logic [3:0] pos);
    logic [7:0] b;
    b = 8'h00;
    if (pos < 4'(NAME_CHARS)) begin
      b = NAME_STR[idx][7'(8*NAME_CHARS - 1 - 8*int'(pos)) -: 8];
    end
    return b;
  endfunction

  function automatic kind_t compact_kind(input logic [7:0] c);
    kind_t k;
    unique case (c)
      CHAR_I:  k = KIND_CALL_ID;
      CHAR_M:  k = KIND_CONTACT;
      CHAR_L:  k = KIND_CONTENT_LENGTH;
      CHAR_C:  k = KIND_CONTENT_TYPE;
      CHAR_F:  k = KIND_FROM;
      CHAR_T:  k = KIND_TO;
      CHAR_V:  k = KIND_VIA;
      default: k = KIND_OTHER;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/sip_header_name_classifier.sv -----
// ----------------------------------------------------------------------------
// sip_header_name_classifier
// Classifies a SIP header name, streamed one byte per word, into a kind code.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_stall    in_name_char[7:0], in_last_char
//   out_     output     out_valid / out_stall  out_header_kind[3:0]
//
// one byte per cycle sustained unless out_stall holds a final byte; a byte is
// registered, then matched against the name table and the kind is loaded into
// the result register. out_valid rises as the final byte leaves the input register.
// rst_n (synchronous, active low) clears the match state and empties both stages.
// out_stall holds only words carrying a final byte; other bytes keep flowing.

module sip_header_name_classifier (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_name_char,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_header_kind
);

  localparam logic [3:0] LEN_MAX = 4'd15;

  // input register
  logic       s1_valid_r;
  logic [7:0] s1_char_r;
  logic       s1_last_r;

  // match state
  logic [3:0]      length_r, length_nxt;
  shnc_pkg::flags_t flags_r, flags_nxt;
  logic [7:0]      first_r, first_nxt;

  // result register
  logic            out_valid_r;
  shnc_pkg::kind_t kind_r, kind_nxt;

  logic       out_free;
  logic       s1_adv;
  logic       in_acc;
  logic [7:0] c;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && (!s1_last_r || out_free);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign c        = shnc_pkg::fold_case(s1_char_r);

  always_comb begin
    flags_nxt = flags_r;
    for (int k = 0; k < shnc_pkg::NUM_NAMES; k++) begin
      if (length_r >= shnc_pkg::NAME_LEN[k]) begin
        flags_nxt[k] = 1'b0;
      end else if (k == shnc_pkg::ROUTE_INDEX && length_r == 4'd0) begin
        flags_nxt[k] = flags_r[k];
      end else if (c != shnc_pkg::name_byte(4'(k), length_r)) begin
        flags_nxt[k] = 1'b0;
      end
    end
    first_nxt  = (length_r == 4'd0) ? c : first_r;
    length_nxt = (length_r < LEN_MAX) ? length_r + 4'd1 : length_r;

    // lowest matching name of the right length wins
    kind_nxt = shnc_pkg::KIND_OTHER;
    if (length_nxt == 4'd1) begin
      kind_nxt = shnc_pkg::compact_kind(first_nxt);
    end else begin
      for (int k = shnc_pkg::NUM_NAMES - 1; k >= 0; k--) begin
        if (flags_nxt[k] && shnc_pkg::NAME_LEN[k] == length_nxt) begin
          kind_nxt = shnc_pkg::kind_t'(4'(k + 1));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      length_r    <= 4'd0;
      flags_r     <= '1;
      first_r     <= 8'h00;
    end else begin
      if (in_acc) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv && s1_last_r) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        if (s1_last_r) begin
          length_r <= 4'd0;
          flags_r  <= '1;
          first_r  <= 8'h00;
        end else begin
          length_r <= length_nxt;
          flags_r  <= flags_nxt;
          first_r  <= first_nxt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_char_r <= in_name_char;
      s1_last_r <= in_last_char;
    end
    if (s1_adv && s1_last_r) begin
      kind_r <= kind_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_header_kind = kind_r;

  // state is back at its idle value after a final byte
  a_state_clear: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && s1_last_r |=> length_r == 4'd0 && flags_r == '1 && first_r == 8'h00)
    else $error("match state not cleared after final byte");

  // a result only follows a final byte leaving the input register
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv && s1_last_r))
    else $error("result without final byte");

  // stalling the input only happens with a held final byte
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && s1_last_r && out_valid_r && out_stall)
    else $error("input stalled without a blocked result");

  // a held result is not overwritten
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(kind_r))
    else $error("stalled result overwritten");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Streams SIP header names into sip_header_name_classifier a byte at a time,
// mixing whole standard names in random letter case, compact forms, damaged
// and over-long names and random bytes, and checks every header kind coming
// out against a directed table entry or a running prediction of the name matcher.
// ----------------------------------------------------------------------------
module testbench;

  typedef struct {
    string           text;
    shnc_pkg::kind_t kind;
    bit              fixed;
  } name_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  logic [7:0] in_name_char;
  logic       in_last_char;
  logic       out_valid;
  logic       out_stall;
  logic [3:0] out_header_kind;

  // expected kinds, written by the sender and read by the checker
  shnc_pkg::kind_t exp_kind [1024];
  int              exp_wr = 0;
  int              exp_rd = 0;
  logic [7:0]      name_buf[$];
  int              errors = 0;
  int              n_sent = 0;
  bit              idle_on = 1'b1;
  bit              hold_req = 1'b0;

  // running match state of the name being received
  logic [3:0]                     seen_len = 4'd0;
  logic [shnc_pkg::NUM_NAMES-1:0] live_names = '1;
  logic [7:0]                     lead_char = 8'h00;

  string std_name [shnc_pkg::NUM_NAMES] = '{
    "to", "via", "from", "cseq", "rseq", "rack", "route", "call-id",
    "contact", "require", "content-type", "record-route", "content-length"
  };

  name_row_t dir_rows [] = '{
    '{"t",    shnc_pkg::KIND_TO,             1'b1},
    '{"V",    shnc_pkg::KIND_VIA,            1'b1},
    '{"I",    shnc_pkg::KIND_CALL_ID,        1'b1},
    '{"m",    shnc_pkg::KIND_CONTACT,        1'b1},
    '{"L",    shnc_pkg::KIND_CONTENT_LENGTH, 1'b1},
    '{"c",    shnc_pkg::KIND_CONTENT_TYPE,   1'b1},
    '{"F",    shnc_pkg::KIND_FROM,           1'b1},
    '{"x",    shnc_pkg::KIND_OTHER,          1'b1},
    '{"\377", shnc_pkg::KIND_OTHER,          1'b1},
    '{"To",   shnc_pkg::KIND_TO,             1'b1},
    '{"VIA",  shnc_pkg::KIND_VIA,            1'b1},
    '{"From", shnc_pkg::KIND_FROM,           1'b1},
    '{"cSeq", shnc_pkg::KIND_CSEQ,           1'b1},
    '{"RSEQ", shnc_pkg::KIND_RSEQ,           1'b1},
    '{"rack", shnc_pkg::KIND_RACK,           1'b1},
    '{"Route", shnc_pkg::KIND_ROUTE,         1'b1},
    '{"xoute", shnc_pkg::KIND_OTHER,         1'b0},
    '{"Call-ID", shnc_pkg::KIND_CALL_ID,     1'b1},
    '{"Contact", shnc_pkg::KIND_CONTACT,     1'b1},
    '{"REQUIRE", shnc_pkg::KIND_REQUIRE,     1'b1},
    '{"content-type", shnc_pkg::KIND_CONTENT_TYPE, 1'b1},
    '{"Record-Route", shnc_pkg::KIND_RECORD_ROUTE, 1'b1},
    '{"Content-Length", shnc_pkg::KIND_CONTENT_LENGTH, 1'b1},
    '{"Content-Lengthx", shnc_pkg::KIND_OTHER, 1'b0},
    '{"content-length-xyz", shnc_pkg::KIND_OTHER, 1'b1},
    '{"[o",   shnc_pkg::KIND_OTHER,          1'b0},
    '{"@ia",  shnc_pkg::KIND_OTHER,          1'b0}
  };

  sip_header_name_classifier i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_name_char    (in_name_char),
    .in_last_char    (in_last_char),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_header_kind (out_header_kind)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // advances the match state by one byte; returns 1 with the kind on a final byte
  function automatic bit classify_byte(input logic [7:0] raw, input logic last,
                                       output shnc_pkg::kind_t kind);
    logic [7:0] c;
    int         k;
    c = raw;
    if (raw >= "A" && raw <= "Z") begin
      c = raw + 8'h20;
    end
    kind = shnc_pkg::KIND_OTHER;
    if (seen_len == 4'd0) begin
      lead_char = c;
    end
    for (k = 0; k < shnc_pkg::NUM_NAMES; k++) begin
      if (int'(seen_len) >= std_name[k].len()) begin
        live_names[k] = 1'b0;
      end else if (!(k == shnc_pkg::ROUTE_INDEX && seen_len == 4'd0) &&
                   c != 8'(std_name[k][int'(seen_len)])) begin
        live_names[k] = 1'b0;
      end
    end
    if (seen_len != 4'd15) begin
      seen_len = seen_len + 4'd1;
    end
    if (!last) begin
      return 1'b0;
    end
    if (seen_len == 4'd1) begin
      case (lead_char)
        shnc_pkg::CHAR_I: kind = shnc_pkg::KIND_CALL_ID;
        shnc_pkg::CHAR_M: kind = shnc_pkg::KIND_CONTACT;
        shnc_pkg::CHAR_L: kind = shnc_pkg::KIND_CONTENT_LENGTH;
        shnc_pkg::CHAR_C: kind = shnc_pkg::KIND_CONTENT_TYPE;
        shnc_pkg::CHAR_F: kind = shnc_pkg::KIND_FROM;
        shnc_pkg::CHAR_T: kind = shnc_pkg::KIND_TO;
        shnc_pkg::CHAR_V: kind = shnc_pkg::KIND_VIA;
        default:          kind = shnc_pkg::KIND_OTHER;
      endcase
    end else begin
      for (k = shnc_pkg::NUM_NAMES - 1; k >= 0; k--) begin
        if (live_names[k] && std_name[k].len() == int'(seen_len)) begin
          kind = shnc_pkg::kind_t'(4'(k + 1));
        end
      end
    end
    seen_len   = 4'd0;
    live_names = '1;
    lead_char  = 8'h00;
    return 1'b1;
  endfunction

  function automatic logic [7:0] mix_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

  // offers one word, called and returning at a falling edge
  task automatic send_byte(input logic [7:0] c, input logic last, input bit fixed,
                           input shnc_pkg::kind_t fixed_kind);
    shnc_pkg::kind_t k;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid     = 1'b1;
    in_name_char = c;
    in_last_char = last;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    if (classify_byte(c, last, k)) begin
      exp_kind[exp_wr] = fixed ? fixed_kind : k;
      exp_wr++;
    end
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_name(input bit fixed, input shnc_pkg::kind_t fixed_kind);
    int i;
    for (i = 0; i < name_buf.size(); i++) begin
      send_byte(name_buf[i], i == name_buf.size() - 1, fixed, fixed_kind);
    end
  endtask

  // receiver: random stall bursts, plus one long hold on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_done) begin
        out_stall = 1'b1;
        repeat (300) @(negedge clk);
        hold_done = 1'b1;
        out_stall = 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    shnc_pkg::kind_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (exp_rd == exp_wr) begin
        $display("%0t: unexpected header kind, expected none, got %0d", $time,
                 out_header_kind);
        errors++;
      end else begin
        want = exp_kind[exp_rd];
        exp_rd++;
        if (out_header_kind !== want) begin
          $display("%0t: header kind mismatch, expected %0d, got %0d", $time,
                   want, out_header_kind);
          errors++;
        end
      end
    end
  end

  initial begin
    int    r;
    int    i;
    int    k;
    int    len;
    int    pos;
    bit    held;
    string compact;
    held         = 1'b0;
    compact      = "imlcftv";
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_name_char = 8'h00;
    in_last_char = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_rows[n]) begin
      name_buf.delete();
      for (i = 0; i < dir_rows[n].text.len(); i++) begin
        name_buf.insert(name_buf.size(), dir_rows[n].text[i]);
      end
      send_name(dir_rows[n].fixed, dir_rows[n].kind);
    end

    while (n_sent < 800) begin
      if (n_sent >= 680) begin
        idle_on = 1'b0;
      end
      // long receiver hold while names keep coming
      if (!held && n_sent >= 300) begin
        hold_req = 1'b1;
        held     = 1'b1;
      end
      name_buf.delete();
      r = $urandom_range(0, 99);
      k = $urandom_range(0, shnc_pkg::NUM_NAMES - 1);
      if (r < 72) begin
        for (i = 0; i < std_name[k].len(); i++) begin
          name_buf.insert(name_buf.size(), mix_case(std_name[k][i]));
        end
        if (k == shnc_pkg::ROUTE_INDEX && $urandom_range(0, 2) == 0) begin
          name_buf[0] = 8'($urandom_range(0, 255));
        end
        // damaged names
        if (r >= 55) begin
          pos = $urandom_range(0, name_buf.size() - 1);
          case ($urandom_range(0, 3))
            0: begin
              len = $urandom_range(1, name_buf.size());
              while (name_buf.size() > len) begin
                name_buf.delete(name_buf.size() - 1);
              end
            end
            1: name_buf.insert(name_buf.size(), 8'($urandom_range(0, 255)));
            2: name_buf[pos] = 8'($urandom_range(0, 255));
            default: name_buf[pos] = name_buf[pos] ^ (8'h01 << $urandom_range(0, 7));
          endcase
        end
      end else if (r < 84) begin
        if ($urandom_range(0, 3) == 0) begin
          name_buf.insert(name_buf.size(), 8'($urandom_range(0, 255)));
        end else begin
          name_buf.insert(name_buf.size(), mix_case(compact[$urandom_range(0, 6)]));
        end
      end else if (r < 92) begin
        // past the saturation point of the length count
        for (i = 0; i < std_name[k].len(); i++) begin
          name_buf.insert(name_buf.size(), mix_case(std_name[k][i]));
        end
        len = $urandom_range(15, 24);
        while (name_buf.size() < len) begin
          name_buf.insert(name_buf.size(), mix_case(8'($urandom_range("a", "z"))));
        end
      end else begin
        len = $urandom_range(1, 20);
        for (i = 0; i < len; i++) begin
          name_buf.insert(name_buf.size(), 8'($urandom_range(0, 255)));
        end
      end
      send_name(1'b0, shnc_pkg::KIND_OTHER);
    end
    in_valid = 1'b0;

    while (exp_rd != exp_wr) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("sip_header_name_classifier test passed");
    end else begin
      $display("sip_header_name_classifier test failed");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("sip_header_name_classifier test failed");
    $finish;
  end

endmodule

// ----- sip_header_name_classifier.f -----
rtl/shnc_pkg.sv
rtl/sip_header_name_classifier.sv
test/testbench.sv
